### hw/rtl/fati_pkg.sv
// shared types, constants and codes for the frequency/attenuation table interpolator
// no dependencies
package fati_pkg;
	localparam int DEPTH = 1024;
	localparam int IDX_W = 10;
	localparam int CNT_W = 11;
	localparam int FREQ_W = 40;
	localparam int ATT_W = 16;
	localparam int OFS_W = 17;
	localparam int ST_W = 3;
	localparam int MAG_W = ATT_W + 1;
	localparam int PROD_W = MAG_W + FREQ_W;

	localparam logic [1:0] REQ_LOAD = 2'd0;
	localparam logic [1:0] REQ_SETREF = 2'd1;
	localparam logic [1:0] REQ_LOOKUP = 2'd2;

	localparam logic [ST_W-1:0] ST_OK = 3'd0;
	localparam logic [ST_W-1:0] ST_NO_TABLE = 3'd1;
	localparam logic [ST_W-1:0] ST_REF_RANGE = 3'd2;
	localparam logic [ST_W-1:0] ST_CLAMP_LO = 3'd3;
	localparam logic [ST_W-1:0] ST_CLAMP_HI = 3'd4;

	typedef struct packed {
		logic [1:0] req_type;
		logic [IDX_W-1:0] entry_index;
		logic [FREQ_W-1:0] frequency;
		logic signed [ATT_W-1:0] entry_att;
		logic entry_last;
	} req_t;

	typedef struct packed {
		logic signed [OFS_W-1:0] att_offset;
		logic [ST_W-1:0] status;
		logic [FREQ_W-1:0] ref_freq_out;
	} rsp_t;

	// divider control/status
	typedef struct packed {
		logic start;
		logic [PROD_W-1:0] num;
		logic [FREQ_W-1:0] den;
	} div_cmd_t;

	typedef struct packed {
		logic done;
		logic [PROD_W-1:0] quot;
	} div_sts_t;
endpackage

### hw/rtl/fati_if.sv
// valid/ready channel interfaces for requests and results
// depends on fati_pkg
interface fati_req_if;
	logic valid;
	logic ready;
	fati_pkg::req_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface fati_rsp_if;
	logic valid;
	logic ready;
	fati_pkg::rsp_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

### hw/rtl/freq_att_table_interpolator.sv
// top level: request sequencer, bisection search and interpolation
// depends on fati_pkg, fati_if, fati_store, fati_div
//
// channel | dir | fields
// req     | in  | req_type entry_index frequency entry_att entry_last
// rsp     | out | att_offset status ref_freq_out
//
// load, zero reference, no-table and unknown items go straight to the output; clamp or
// end hit: end entries read only; equal-frequency bracket: bisection (10 steps on a
// full table) and bracket reads; interpolation adds the multiply and 57-bit divide.
// reset clears count, enable and reference; the entry memory is not cleared.
// one item at a time; an output register holds the result, so the next request is
// taken while it waits; a second finished result waits in S_OUT until the first is taken.
module freq_att_table_interpolator (
	input logic clk,
	input logic arst_n,
	fati_req_if.sink req,
	fati_rsp_if.source rsp
);
	localparam int FW = fati_pkg::FREQ_W;
	localparam int AW = fati_pkg::ATT_W;
	localparam int IW = fati_pkg::IDX_W;
	localparam int CW = fati_pkg::CNT_W;
	localparam int PW = fati_pkg::PROD_W;
	localparam int OW = fati_pkg::OFS_W;
	localparam int HW = FW / 2;
	localparam int PPW = fati_pkg::MAG_W + HW;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_RD0 = 4'd1;
	localparam logic [3:0] S_GOT0 = 4'd2;
	localparam logic [3:0] S_GOTL = 4'd3;
	localparam logic [3:0] S_BIS = 4'd4;
	localparam logic [3:0] S_BISW = 4'd5;
	localparam logic [3:0] S_RDLO = 4'd6;
	localparam logic [3:0] S_GOTLO = 4'd7;
	localparam logic [3:0] S_GOTHI = 4'd8;
	localparam logic [3:0] S_MUL = 4'd9;
	localparam logic [3:0] S_DIV = 4'd10;
	localparam logic [3:0] S_FIN = 4'd11;
	localparam logic [3:0] S_OUT = 4'd12;
	localparam logic [3:0] S_MUL2 = 4'd13;
	localparam logic [3:0] S_DST = 4'd14;

	logic [3:0] state_q;
	fati_pkg::req_t r_q;
	logic [CW-1:0] count_q;
	logic en_q;
	logic signed [AW-1:0] ref_att_q;
	logic [FW-1:0] ref_freq_q;
	logic [IW-1:0] lo_q, hi_q, mid_q;
	logic [FW-1:0] flo_q;
	logic signed [AW-1:0] alo_q;
	logic signed [AW+1:0] val_q;
	logic [fati_pkg::ST_W-1:0] st_q;
	logic [FW-1:0] den_q;
	logic [FW-1:0] num_q;
	logic neg_q;
	logic [fati_pkg::MAG_W-1:0] mag_q;
	logic [PW-1:0] prod_q;
	fati_pkg::rsp_t res_q;
	fati_pkg::rsp_t out_q;
	logic out_vld_q;

	logic mem_we;
	logic [IW-1:0] mem_addr;
	logic [FW-1:0] rfreq;
	logic signed [AW-1:0] ratt;
	fati_pkg::div_cmd_t dcmd;
	fati_pkg::div_sts_t dsts;
	logic [IW-1:0] last_idx;
	logic signed [AW:0] d_att;
	logic signed [AW+2:0] diffv;
	logic signed [AW+1:0] qs;
	logic [IW:0] midsum;
	logic req_xfer;
	logic [HW-1:0] mul_b;
	logic [PPW-1:0] pp;

	assign req_xfer = req.valid && req.ready;
	assign req.ready = (state_q == S_IDLE);
	assign last_idx = IW'(count_q - 1'b1);
	assign midsum = {1'b0, lo_q} + {1'b0, hi_q};

	// memory address select
	always_comb begin
		mem_we = 1'b0;
		mem_addr = mid_q;
		if (state_q == S_IDLE) begin
			mem_addr = req.data.entry_index;
			mem_we = req_xfer && (req.data.req_type == fati_pkg::REQ_LOAD);
		end else if (state_q == S_RD0) begin
			mem_addr = '0;
		end else if (state_q == S_GOT0) begin
			mem_addr = last_idx;
		end else if (state_q == S_BIS) begin
			mem_addr = midsum[IW:1];
		end else if (state_q == S_RDLO) begin
			mem_addr = lo_q;
		end else if (state_q == S_GOTLO) begin
			mem_addr = hi_q;
		end
	end

	fati_store u_store (
		.clk(clk), .we(mem_we), .addr(mem_addr),
		.wfreq(req.data.frequency), .watt(req.data.entry_att),
		.rfreq(rfreq), .ratt(ratt)
	);

	assign dcmd.start = (state_q == S_DST);
	assign dcmd.num = prod_q;
	assign dcmd.den = den_q;

	fati_div u_div (.clk(clk), .arst_n(arst_n), .cmd(dcmd), .sts(dsts));

	// quotient saturated to the signed range (cap is far above any useful value)
	always_comb begin
		if (dsts.quot > PW'(2 ** (AW + 1) - 1)) qs = (AW + 2)'(2 ** (AW + 1) - 1);
		else qs = (AW + 2)'(dsts.quot);
	end
	assign d_att = {ratt[AW-1], ratt} - {alo_q[AW-1], alo_q};
	assign diffv = {val_q[AW+1], val_q} - (AW + 3)'(ref_att_q);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			en_q <= 1'b0;
			ref_att_q <= '0;
			ref_freq_q <= '0;
			res_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (req_xfer) begin
						r_q <= req.data;
						st_q <= fati_pkg::ST_OK;
						res_q.att_offset <= '0;
						unique case (req.data.req_type)
							fati_pkg::REQ_LOAD: begin
								if (req.data.entry_last) begin
									count_q <= CW'(req.data.entry_index) + 1'b1;
									en_q <= 1'b1;
								end
								res_q.status <= fati_pkg::ST_OK;
								res_q.ref_freq_out <= ref_freq_q;
								state_q <= S_OUT;
							end
							fati_pkg::REQ_SETREF: begin
								if (req.data.frequency == '0) begin
									en_q <= 1'b0;
									ref_att_q <= '0;
									ref_freq_q <= '0;
									res_q.status <= fati_pkg::ST_OK;
									res_q.ref_freq_out <= '0;
									state_q <= S_OUT;
								end else if (count_q == '0) begin
									res_q.status <= fati_pkg::ST_NO_TABLE;
									res_q.ref_freq_out <= ref_freq_q;
									state_q <= S_OUT;
								end else begin
									state_q <= S_RD0;
								end
							end
							fati_pkg::REQ_LOOKUP: begin
								if (!en_q || count_q == '0) begin
									res_q.status <= fati_pkg::ST_NO_TABLE;
									res_q.ref_freq_out <= ref_freq_q;
									state_q <= S_OUT;
								end else begin
									state_q <= S_RD0;
								end
							end
							default: begin
								res_q.status <= fati_pkg::ST_OK;
								res_q.ref_freq_out <= ref_freq_q;
								state_q <= S_OUT;
							end
						endcase
					end
				end
				S_RD0: state_q <= S_GOT0;
				S_GOT0: begin
					// first entry now on the read port
					lo_q <= '0;
					hi_q <= last_idx;
					flo_q <= rfreq;
					alo_q <= ratt;
					if (r_q.frequency < rfreq) begin
						val_q <= (AW + 2)'(ratt);
						st_q <= fati_pkg::ST_CLAMP_LO;
						state_q <= S_FIN;
					end else begin
						state_q <= S_GOTL;
					end
				end
				S_GOTL: begin
					// last entry now on the read port, first entry held
					if (r_q.frequency > rfreq) begin
						val_q <= (AW + 2)'(ratt);
						st_q <= fati_pkg::ST_CLAMP_HI;
						state_q <= S_FIN;
					end else if (r_q.frequency == flo_q) begin
						val_q <= (AW + 2)'(alo_q);
						state_q <= S_FIN;
					end else if (r_q.frequency == rfreq) begin
						val_q <= (AW + 2)'(ratt);
						state_q <= S_FIN;
					end else begin
						state_q <= S_BIS;
					end
				end
				S_BIS: begin
					if (IW'(hi_q - lo_q) > IW'(1)) begin
						mid_q <= midsum[IW:1];
						state_q <= S_BISW;
					end else begin
						state_q <= S_RDLO;
					end
				end
				S_BISW: begin
					// compare against mid entry, read issued last cycle
					if (r_q.frequency > rfreq) lo_q <= mid_q;
					else hi_q <= mid_q;
					state_q <= S_BIS;
				end
				S_RDLO: state_q <= S_GOTLO;
				S_GOTLO: begin
					flo_q <= rfreq;
					alo_q <= ratt;
					state_q <= S_GOTHI;
				end
				S_GOTHI: begin
					if (rfreq <= flo_q) begin
						val_q <= (AW + 2)'(alo_q);
						state_q <= S_FIN;
					end else begin
						den_q <= rfreq - flo_q;
						num_q <= r_q.frequency - flo_q;
						neg_q <= d_att[AW];
						mag_q <= d_att[AW] ? (AW + 1)'(-d_att) : (AW + 1)'(d_att);
						state_q <= S_MUL;
					end
				end
				S_MUL: state_q <= S_MUL2;
				S_MUL2: state_q <= S_DST;
				S_DST: state_q <= S_DIV;
				S_DIV: begin
					if (dsts.done) begin
						val_q <= neg_q ? (AW + 2)'(alo_q) - qs : (AW + 2)'(alo_q) + qs;
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (r_q.req_type == fati_pkg::REQ_SETREF) begin
						if (st_q != fati_pkg::ST_OK) begin
							res_q.status <= fati_pkg::ST_REF_RANGE;
							res_q.ref_freq_out <= ref_freq_q;
						end else begin
							en_q <= 1'b1;
							ref_freq_q <= r_q.frequency;
							res_q.ref_freq_out <= r_q.frequency;
							res_q.status <= fati_pkg::ST_OK;
							if (val_q > (AW + 2)'(2 ** (AW - 1) - 1))
								ref_att_q <= AW'(2 ** (AW - 1) - 1);
							else if (val_q < -(AW + 2)'(2 ** (AW - 1)))
								ref_att_q <= AW'(-(2 ** (AW - 1)));
							else
								ref_att_q <= AW'(val_q);
						end
					end else begin
						res_q.status <= st_q;
						res_q.ref_freq_out <= ref_freq_q;
						if (diffv > (AW + 3)'(2 ** OW - 1))
							res_q.att_offset <= OW'(2 ** OW - 1);
						else if (diffv < -(AW + 3)'(2 ** OW - 1))
							res_q.att_offset <= OW'(-(2 ** OW - 1));
						else
							res_q.att_offset <= OW'(diffv);
					end
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (!out_vld_q || rsp.ready) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// shared 17 x 20 multiplier: low half of the frequency term, then high half
	assign mul_b = (state_q == S_MUL) ? num_q[HW-1:0] : num_q[FW-1:HW];
	assign pp = PPW'(mag_q) * PPW'(mul_b);

	// product register ahead of the divider, built from the low and then the high partial product
	always_ff @(posedge clk) begin
		if (state_q == S_MUL) begin
			prod_q <= PW'(pp);
		end else if (state_q == S_MUL2) begin
			prod_q <= prod_q + {pp, HW'(0)};
		end
	end

	// output register, loaded when empty or being emptied
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
			out_q <= '0;
		end else if (state_q == S_OUT && (!out_vld_q || rsp.ready)) begin
			out_vld_q <= 1'b1;
			out_q <= res_q;
		end else if (rsp.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	assign rsp.valid = out_vld_q;
	assign rsp.data = out_q;

	// the divider only finishes while the sequencer waits for it
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		dsts.done |-> state_q == S_DIV) else $error("divider done outside wait");
	// bisection bounds stay ordered
	a_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_BIS) |-> lo_q < hi_q) else $error("bisection bounds crossed");
	// a finished result holds until taken
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && !rsp.ready) |=> rsp.valid && $stable(out_q))
		else $error("result dropped while stalled");
endmodule

### hw/rtl/fati_div.sv
// restoring divider, one quotient bit per cycle
// depends on fati_pkg
module fati_div (
	input logic clk,
	input logic arst_n,
	input fati_pkg::div_cmd_t cmd,
	output fati_pkg::div_sts_t sts
);
	localparam int CW = $clog2(fati_pkg::PROD_W + 1);
	logic [CW-1:0] cnt_q;
	logic busy_q;
	logic [fati_pkg::PROD_W-1:0] num_q;
	logic [fati_pkg::FREQ_W-1:0] den_q;
	logic [fati_pkg::FREQ_W:0] rem_q;
	logic done_q;
	logic [fati_pkg::FREQ_W:0] shifted;
	logic [fati_pkg::FREQ_W:0] diff;

	// one shift and trial subtract
	assign shifted = {rem_q[fati_pkg::FREQ_W-1:0], num_q[fati_pkg::PROD_W-1]};
	assign diff = shifted - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				busy_q <= 1'b1;
				cnt_q <= CW'(fati_pkg::PROD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath: num_q holds dividend then quotient
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			num_q <= cmd.num;
			den_q <= cmd.den;
			rem_q <= '0;
		end else if (busy_q) begin
			if (!diff[fati_pkg::FREQ_W]) begin
				rem_q <= diff;
				num_q <= {num_q[fati_pkg::PROD_W-2:0], 1'b1};
			end else begin
				rem_q <= shifted;
				num_q <= {num_q[fati_pkg::PROD_W-2:0], 1'b0};
			end
		end
	end

	assign sts.done = done_q;
	assign sts.quot = num_q;
endmodule

### hw/rtl/fati_store.sv
// entry memory: frequency and attenuation, one port, registered read
// depends on fati_pkg
module fati_store (
	input logic clk,
	input logic we,
	input logic [fati_pkg::IDX_W-1:0] addr,
	input logic [fati_pkg::FREQ_W-1:0] wfreq,
	input logic signed [fati_pkg::ATT_W-1:0] watt,
	output logic [fati_pkg::FREQ_W-1:0] rfreq,
	output logic signed [fati_pkg::ATT_W-1:0] ratt
);
	logic [fati_pkg::FREQ_W+fati_pkg::ATT_W-1:0] mem [fati_pkg::DEPTH];

	// write and read one entry a cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= {wfreq, watt};
		end
		{rfreq, ratt} <= mem[addr];
	end
endmodule
